### hdl/dsc_pkg.sv
// shared constants, types and helper functions for the dictionary spell checker
package dsc_pkg;

  // store geometry
  localparam int DICT_WORDS = 1024;
  localparam int WORD_CHARS = 20;
  localparam int ADDR_W     = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
  localparam int COUNT_W    = $clog2(DICT_WORDS + 1);
  localparam int CHAR_IDX_W = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
  localparam int ENT_LEN_W  = $clog2(WORD_CHARS + 1);

  // token length counter
  localparam int TOK_LEN_W = 12;
  localparam logic [TOK_LEN_W-1:0] TOK_LEN_MAX = 12'd4095;

  // operation codes
  localparam logic [1:0] OP_DICT = 2'd0;
  localparam logic [1:0] OP_TEXT = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  // token classes
  localparam logic [1:0] CLS_LETTER = 2'd0;
  localparam logic [1:0] CLS_PUNCT  = 2'd1;
  localparam logic [1:0] CLS_SPACE  = 2'd2;
  localparam logic [1:0] CLS_NONE   = 2'd3;

  // characters of interest
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_NL    = 8'h0a;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_EXCL  = 8'h21;
  localparam logic [7:0] CHR_COMMA = 8'h2c;
  localparam logic [7:0] CHR_DOT   = 8'h2e;
  localparam logic [7:0] CHR_QUEST = 8'h3f;
  localparam logic [7:0] CHR_UP_A  = 8'h41;
  localparam logic [7:0] CHR_UP_Z  = 8'h5a;
  localparam logic [7:0] CHR_LO_A  = 8'h61;
  localparam logic [7:0] CHR_LO_Z  = 8'h7a;
  localparam logic [7:0] CASE_GAP  = 8'd32;

  // one dictionary entry as held in the word ram
  typedef struct packed {
    logic [ENT_LEN_W-1:0]           len;
    logic [WORD_CHARS-1:0][7:0]     chars;
  } dsc_entry_t;

  // word ram write port
  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    dsc_entry_t          entry;
  } dsc_wr_t;

  // search sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } dsc_state_t;

  // character class of a text byte
  function automatic logic [1:0] classify(input logic [7:0] c);
    logic [1:0] cls;
    if ((c >= CHR_UP_A && c <= CHR_UP_Z) || (c >= CHR_LO_A && c <= CHR_LO_Z)) begin
      cls = CLS_LETTER;
    end else if (c == CHR_COMMA || c == CHR_DOT || c == CHR_EXCL || c == CHR_QUEST) begin
      cls = CLS_PUNCT;
    end else if (c == CHR_SPACE) begin
      cls = CLS_SPACE;
    end else begin
      cls = CLS_NONE;
    end
    return cls;
  endfunction

  // token char t matches entry char d: equal, or uppercase t against lowercase d
  function automatic logic char_match(input logic [7:0] t, input logic [7:0] d);
    logic upper;
    upper = (t >= CHR_UP_A) && (t <= CHR_UP_Z);
    return (t == d) || (upper && ((t + CASE_GAP) == d));
  endfunction

endpackage

### hdl/dictionary_spell_check.sv
// top level of the dictionary spell checker
//
// Input channel (text_valid / text_stall) carries operation and char_byte:
// dictionary bytes first, newline or NUL closing each word, then text bytes
// and an end of text marker. Output channel (result_valid / result_stall)
// carries one result per closed token: token_class, token_length, found.
// A transfer happens on a rising edge with valid high and stall low.
// Punctuation and space tokens are reported through the pending stage and
// the output register after the byte that closes them. A letter token is
// compared against the stored words one entry per cycle through the read
// port of the word ram, stopping at the first match or after the last of
// word_count entries (word_count <= 1024); with an empty dictionary a letter
// token is reported like the other tokens. The input stalls while a search
// runs and while a result sits in the pending stage; a result stays there
// while a stalled result holds the output register. All other bytes are
// taken one per cycle.
// Reset empties the dictionary (word count zero), closes any open token and
// drops undelivered results; the word ram contents are not cleared.
module dictionary_spell_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            text_valid,
  output logic                            text_stall,
  input  logic [1:0]                      operation,
  input  logic [7:0]                      char_byte,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [1:0]                      token_class,
  output logic [dsc_pkg::TOK_LEN_W-1:0]   token_length,
  output logic                            found
);

  dsc_pkg::dsc_state_t state;

  // dictionary fill
  logic [dsc_pkg::WORD_CHARS-1:0][7:0]  dict_buf;
  logic [dsc_pkg::ENT_LEN_W-1:0]        fill_pos;
  logic                                 fill_ovf;
  logic [dsc_pkg::COUNT_W-1:0]          word_count;

  // open token
  logic [dsc_pkg::WORD_CHARS-1:0][7:0]  tok_chars;
  logic [dsc_pkg::TOK_LEN_W-1:0]        tok_len;
  logic [1:0]                           cur_class;

  // search key and sequencer
  logic [dsc_pkg::WORD_CHARS-1:0][7:0]  key_chars;
  logic [dsc_pkg::TOK_LEN_W-1:0]        key_len;
  logic [dsc_pkg::COUNT_W-1:0]          srch_idx;
  logic [dsc_pkg::COUNT_W-1:0]          srch_limit;
  logic                                 cmp_valid;
  logic                                 cmp_last;

  // pending result
  logic                                 pend_valid;
  logic [1:0]                           pend_class;
  logic [dsc_pkg::TOK_LEN_W-1:0]        pend_len;
  logic                                 pend_found;

  // ram ports
  dsc_pkg::dsc_wr_t                     ram_wr;
  logic                                 rd_en;
  dsc_pkg::dsc_entry_t                  rd_entry;

  // input decode
  logic       accept;
  logic [1:0] byte_cls;
  logic       tok_open;
  logic       tok_extend;
  logic       tok_close;
  logic       tok_start;
  logic       dict_close;
  logic       dict_put;
  logic       out_load;
  logic       search_done;
  logic       entry_match;
  logic [dsc_pkg::WORD_CHARS-1:0] lane_ok;

  assign text_stall = (state != dsc_pkg::ST_IDLE) || pend_valid;
  assign accept     = text_valid && !text_stall;
  assign byte_cls   = dsc_pkg::classify(char_byte);
  assign tok_open   = (cur_class != dsc_pkg::CLS_NONE);

  assign tok_extend = accept && (operation == dsc_pkg::OP_TEXT) && tok_open &&
                      (byte_cls == cur_class);
  assign tok_close  = accept && tok_open &&
                      (((operation == dsc_pkg::OP_TEXT) && (byte_cls != cur_class)) ||
                       (operation == dsc_pkg::OP_END));
  assign tok_start  = accept && (operation == dsc_pkg::OP_TEXT) &&
                      (byte_cls != dsc_pkg::CLS_NONE) && !tok_extend;
  assign dict_close = accept && (operation == dsc_pkg::OP_DICT) &&
                      ((char_byte == dsc_pkg::CHR_NL) || (char_byte == dsc_pkg::CHR_NUL));
  assign dict_put   = accept && (operation == dsc_pkg::OP_DICT) && !dict_close;

  // dictionary fill buffer and word count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_pos   <= '0;
      fill_ovf   <= 1'b0;
      word_count <= '0;
    end else if (dict_close) begin
      fill_pos <= '0;
      fill_ovf <= 1'b0;
      if (word_count < dsc_pkg::COUNT_W'(dsc_pkg::DICT_WORDS)) begin
        word_count <= word_count + dsc_pkg::COUNT_W'(1);
      end
    end else if (dict_put) begin
      if (fill_pos < dsc_pkg::ENT_LEN_W'(dsc_pkg::WORD_CHARS)) begin
        fill_pos <= fill_pos + dsc_pkg::ENT_LEN_W'(1);
      end else begin
        fill_ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dict_put && (fill_pos < dsc_pkg::ENT_LEN_W'(dsc_pkg::WORD_CHARS))) begin
      dict_buf[fill_pos[dsc_pkg::CHAR_IDX_W-1:0]] <= char_byte;
    end
  end

  // closing a word writes the whole entry
  always_comb begin
    ram_wr.en          = dict_close && (word_count < dsc_pkg::COUNT_W'(dsc_pkg::DICT_WORDS));
    ram_wr.addr        = word_count[dsc_pkg::ADDR_W-1:0];
    ram_wr.entry.chars = dict_buf;
    ram_wr.entry.len   = fill_ovf ? '0 : fill_pos;
  end

  // open token tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_class <= dsc_pkg::CLS_NONE;
      tok_len   <= '0;
    end else if (tok_extend) begin
      if (tok_len < dsc_pkg::TOK_LEN_MAX) begin
        tok_len <= tok_len + dsc_pkg::TOK_LEN_W'(1);
      end
    end else if (tok_start) begin
      cur_class <= byte_cls;
      tok_len   <= dsc_pkg::TOK_LEN_W'(1);
    end else if (tok_close) begin
      cur_class <= dsc_pkg::CLS_NONE;
      tok_len   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_extend) begin
      if (tok_len < dsc_pkg::TOK_LEN_W'(dsc_pkg::WORD_CHARS)) begin
        tok_chars[tok_len[dsc_pkg::CHAR_IDX_W-1:0]] <= char_byte;
      end
    end else if (tok_start) begin
      tok_chars[0] <= char_byte;
    end
  end

  // word ram
  dsc_word_ram u_ram (
    .clk      (clk),
    .wr       (ram_wr),
    .rd_en    (rd_en),
    .rd_addr  (srch_idx[dsc_pkg::ADDR_W-1:0]),
    .rd_entry (rd_entry)
  );

  // compare the key against the entry just read
  always_comb begin
    for (int i = 0; i < dsc_pkg::WORD_CHARS; i++) begin
      lane_ok[i] = (dsc_pkg::ENT_LEN_W'(i) >= rd_entry.len) ||
                   dsc_pkg::char_match(key_chars[i], rd_entry.chars[i]);
    end
  end

  assign entry_match = (rd_entry.len != '0) &&
                       (key_len == dsc_pkg::TOK_LEN_W'(rd_entry.len)) && (&lane_ok);
  assign rd_en       = (state == dsc_pkg::ST_SEARCH) && (srch_idx < srch_limit);
  assign search_done = (state == dsc_pkg::ST_SEARCH) && cmp_valid && (entry_match || cmp_last);
  assign out_load    = pend_valid && (!result_valid || !result_stall);

  // search sequencer and pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dsc_pkg::ST_IDLE;
      pend_valid <= 1'b0;
      cmp_valid  <= 1'b0;
    end else begin
      cmp_valid <= rd_en;
      if (out_load) begin
        pend_valid <= 1'b0;
      end
      unique case (state)
        dsc_pkg::ST_IDLE: begin
          if (tok_close) begin
            if (cur_class != dsc_pkg::CLS_LETTER) begin
              pend_valid <= 1'b1;
            end else if (word_count == '0) begin
              pend_valid <= 1'b1;
            end else begin
              state <= dsc_pkg::ST_SEARCH;
            end
          end
        end
        dsc_pkg::ST_SEARCH: begin
          if (search_done) begin
            state      <= dsc_pkg::ST_IDLE;
            pend_valid <= 1'b1;
          end
        end
        default: begin
          state <= dsc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // search payload
  always_ff @(posedge clk) begin
    if (tok_close) begin
      pend_class <= cur_class;
      pend_len   <= tok_len;
      pend_found <= (cur_class != dsc_pkg::CLS_LETTER);
      key_chars  <= tok_chars;
      key_len    <= tok_len;
      srch_limit <= word_count;
      srch_idx   <= '0;
    end else begin
      if (rd_en) begin
        srch_idx <= srch_idx + dsc_pkg::COUNT_W'(1);
        cmp_last <= (srch_idx == (srch_limit - dsc_pkg::COUNT_W'(1)));
      end
      if (search_done) begin
        pend_found <= entry_match;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      token_class  <= pend_class;
      token_length <= pend_len;
      found        <= pend_found;
    end
  end

`ifndef SYNTHESIS
  a_pend_not_searching : assert property (@(posedge clk) disable iff (rst)
    !(pend_valid && (state == dsc_pkg::ST_SEARCH)))
    else $error("pending result while a search is running");

  a_search_nonempty : assert property (@(posedge clk) disable iff (rst)
    (state == dsc_pkg::ST_SEARCH) |-> (srch_limit != '0))
    else $error("search started on an empty dictionary");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    word_count <= dsc_pkg::COUNT_W'(dsc_pkg::DICT_WORDS))
    else $error("word count beyond store size");

  a_out_drains : assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !pend_valid) |=> !result_valid)
    else $error("result repeated after transfer");
`endif

endmodule

### hdl/dsc_word_ram.sv
// word ram: one entry per dictionary word, one write and one registered read per cycle
module dsc_word_ram (
  input  logic                           clk,
  input  dsc_pkg::dsc_wr_t               wr,
  input  logic                           rd_en,
  input  logic [dsc_pkg::ADDR_W-1:0]     rd_addr,
  output dsc_pkg::dsc_entry_t            rd_entry
);

  dsc_pkg::dsc_entry_t mem [dsc_pkg::DICT_WORDS];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule
